[hw/rtl/ggap_pkg.sv]
// ----------------------------------------------------------------------------
// ggap_pkg: shared types, constants and helpers for the GGA sentence parser
// Holds the sentence record passed from the parser front to the converter
// back, character codes, field numbers and the saturating digit helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ggap_pkg;

    // Fraction digits kept for minutes and altitude
    localparam logic [2:0] MIN_FRAC_DIGITS = 3'd4;
    localparam logic [2:0] ALT_FRAC_DIGITS = 3'd1;

    // Saturation limits
    localparam logic [19:0] MIN_CAP     = 20'hFFFFF;
    localparam logic [19:0] ALT_POS_CAP = 20'd999999;
    localparam logic [19:0] ALT_NEG_CAP = 20'd99999;
    localparam logic [19:0] LAT_DEG_CAP = 20'd99;
    localparam logic [19:0] LON_DEG_CAP = 20'd255;
    localparam logic [19:0] SAT_CAP     = 20'd99;
    localparam logic [28:0] LAT_CAP     = 29'd90000000;
    localparam logic [28:0] LON_CAP     = 29'd180000000;
    localparam logic [19:0] MICRO       = 20'd1000000;

    // Characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_W     = 8'h57;

    // Field numbers within the sentence
    localparam logic [3:0] FLD_LAT     = 4'd2;
    localparam logic [3:0] FLD_LAT_DIR = 4'd3;
    localparam logic [3:0] FLD_LON     = 4'd4;
    localparam logic [3:0] FLD_LON_DIR = 4'd5;
    localparam logic [3:0] FLD_FIX     = 4'd6;
    localparam logic [3:0] FLD_SAT     = 4'd7;
    localparam logic [3:0] FLD_ALT     = 4'd9;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // One finished sentence
    typedef struct packed {
        logic [6:0]  lat_deg;
        logic [19:0] lat_min;
        logic [2:0]  lat_have;
        logic        lat_long;
        logic [7:0]  lon_deg;
        logic [19:0] lon_min;
        logic [2:0]  lon_have;
        logic        lon_long;
        logic [7:0]  lat_dir;
        logic [7:0]  lon_dir;
        logic [19:0] alt;
        logic [2:0]  alt_have;
        logic        alt_neg;
        logic [6:0]  sat;
        logic        fix;
        logic        cut;
    } rec_t;

    // Decimal number scanner step result
    typedef struct packed {
        logic [19:0] acc;
        logic [2:0]  frac;
        logic        ap;
        logic        nd;
    } dec_t;

    function automatic logic [16:0] pow10(input logic [2:0] n);
        logic [16:0] p;
        case (n)
            3'd0:    p = 17'd1;
            3'd1:    p = 17'd10;
            3'd2:    p = 17'd100;
            3'd3:    p = 17'd1000;
            3'd4:    p = 17'd10000;
            3'd5:    p = 17'd100000;
            default: p = 17'd1;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'h24;
            3'd1:    ch = 8'h47;
            3'd2:    ch = 8'h50;
            3'd3:    ch = 8'h47;
            3'd4:    ch = 8'h47;
            3'd5:    ch = 8'h41;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // acc*10 + digit, saturated at cap
    function automatic logic [19:0] sat_push(input logic [19:0] acc, input logic [3:0] d,
                                             input logic [19:0] cap);
        logic [23:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {20'b0, d};
        return (v > {4'b0, cap}) ? cap : v[19:0];
    endfunction

    // Bring a number with 'have' fraction digits to 'want' digits, saturated
    function automatic logic [19:0] sat_scale(input logic [19:0] acc, input logic [2:0] have,
                                              input logic [2:0] want, input logic [19:0] cap);
        logic [36:0] v;
        v = {17'b0, acc} * {20'b0, pow10(want - have)};
        if (have >= want) begin
            return acc;
        end
        return (v > {17'b0, cap}) ? cap : v[19:0];
    endfunction

    // One character of a decimal number with an optional point
    function automatic dec_t take_decimal(input logic [7:0] c, input logic [19:0] acc,
                                          input logic [2:0] frac, input logic ap,
                                          input logic [2:0] fdig, input logic [19:0] cap);
        dec_t r;
        r.acc  = acc;
        r.frac = frac;
        r.ap   = ap;
        r.nd   = 1'b0;
        if (is_digit(c)) begin
            if (!ap) begin
                r.acc = sat_push(acc, c[3:0], cap);
            end else if (frac < fdig) begin
                r.acc  = sat_push(acc, c[3:0], cap);
                r.frac = frac + 3'd1;
            end
        end else if (c == CH_DOT && !ap) begin
            r.ap = 1'b1;
        end else begin
            r.nd = 1'b1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ggap_front.sv]
// ----------------------------------------------------------------------------
// ggap_front: byte-wise sentence scanner
// Tracks header, field and character position, accumulates digits of the
// GGA fields and pushes one record per matched sentence into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ggap_front #(
    parameter int MAX_SENTENCE = 128
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [7:0]       s_rx_byte,
    input  wire logic             q_full,
    output logic                  q_push,
    output ggap_pkg::rec_t        q_rec
);

    logic [7:0]  byte_count_reg, byte_count_next;
    logic        header_match_reg, header_match_next;
    logic [3:0]  field_reg, field_next;
    logic [4:0]  char_reg, char_next;
    logic [6:0]  lat_deg_reg, lat_deg_next;
    logic [19:0] lat_min_reg, lat_min_next;
    logic [4:0]  lat_len_reg, lat_len_next;
    logic [2:0]  lat_have_reg, lat_have_next;
    logic [7:0]  lon_deg_reg, lon_deg_next;
    logic [19:0] lon_min_reg, lon_min_next;
    logic [4:0]  lon_len_reg, lon_len_next;
    logic [2:0]  lon_have_reg, lon_have_next;
    logic [2:0]  frac_reg, frac_next;
    logic        ap_reg, ap_next;
    logic        nd_reg, nd_next;
    logic [19:0] alt_reg, alt_next;
    logic        alt_neg_reg, alt_neg_next;
    logic [2:0]  alt_have_reg, alt_have_next;
    logic [6:0]  sat_reg, sat_next;
    logic [7:0]  lat_dir_reg, lat_dir_next;
    logic [7:0]  lon_dir_reg, lon_dir_next;
    logic        fix_reg, fix_next;

    logic [7:0]  c;
    logic        take;
    logic        newline;
    logic        cut;
    logic [7:0]  bc_inc;
    logic        ndc;
    logic [19:0] tmp;
    ggap_pkg::dec_t dec;

    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;
    assign c       = s_rx_byte;

    // Per-byte parse
    always_comb begin
        byte_count_next   = byte_count_reg;
        header_match_next = header_match_reg;
        field_next        = field_reg;
        char_next         = char_reg;
        lat_deg_next      = lat_deg_reg;
        lat_min_next      = lat_min_reg;
        lat_len_next      = lat_len_reg;
        lat_have_next     = lat_have_reg;
        lon_deg_next      = lon_deg_reg;
        lon_min_next      = lon_min_reg;
        lon_len_next      = lon_len_reg;
        lon_have_next     = lon_have_reg;
        frac_next         = frac_reg;
        ap_next           = ap_reg;
        nd_next           = nd_reg;
        alt_next          = alt_reg;
        alt_neg_next      = alt_neg_reg;
        alt_have_next     = alt_have_reg;
        sat_next          = sat_reg;
        lat_dir_next      = lat_dir_reg;
        lon_dir_next      = lon_dir_reg;
        fix_next          = fix_reg;
        q_push            = 1'b0;
        q_rec             = '0;
        bc_inc            = byte_count_reg + 8'd1;
        newline           = (c == ggap_pkg::CH_LF);
        cut               = !newline && (bc_inc >= 8'(MAX_SENTENCE));
        ndc               = nd_reg;
        tmp               = '0;
        dec               = '0;

        if (take) begin
            if (byte_count_reg < 8'd6 && c != ggap_pkg::hdr_char(byte_count_reg[2:0])) begin
                header_match_next = 1'b0;
            end
            byte_count_next = bc_inc;

            if (!newline) begin
                if (c == ggap_pkg::CH_COMMA) begin
                    if (field_reg != 4'd15) begin
                        field_next = field_reg + 4'd1;
                    end
                    char_next = '0;
                    ap_next   = 1'b0;
                    frac_next = '0;
                    nd_next   = 1'b0;
                end else begin
                    case (field_reg)
                        ggap_pkg::FLD_LAT: begin
                            if (lat_len_reg != 5'd31) begin
                                lat_len_next = lat_len_reg + 5'd1;
                            end
                            if (char_reg < 5'd2) begin
                                if (!nd_reg && ggap_pkg::is_digit(c)) begin
                                    tmp = ggap_pkg::sat_push({13'b0, lat_deg_reg}, c[3:0],
                                                             ggap_pkg::LAT_DEG_CAP);
                                    lat_deg_next = tmp[6:0];
                                end else begin
                                    nd_next = 1'b1;
                                end
                            end else begin
                                ndc = (char_reg == 5'd2) ? 1'b0 : nd_reg;
                                nd_next = ndc;
                                if (!ndc) begin
                                    dec = ggap_pkg::take_decimal(c, lat_min_reg, frac_reg,
                                              ap_reg, ggap_pkg::MIN_FRAC_DIGITS,
                                              ggap_pkg::MIN_CAP);
                                    lat_min_next  = dec.acc;
                                    frac_next     = dec.frac;
                                    ap_next       = dec.ap;
                                    nd_next       = dec.nd;
                                    lat_have_next = dec.frac;
                                end
                            end
                        end
                        ggap_pkg::FLD_LAT_DIR: begin
                            if (char_reg == 5'd0) begin
                                lat_dir_next = c;
                            end
                        end
                        ggap_pkg::FLD_LON: begin
                            if (lon_len_reg != 5'd31) begin
                                lon_len_next = lon_len_reg + 5'd1;
                            end
                            if (char_reg < 5'd3) begin
                                if (!nd_reg && ggap_pkg::is_digit(c)) begin
                                    tmp = ggap_pkg::sat_push({12'b0, lon_deg_reg}, c[3:0],
                                                             ggap_pkg::LON_DEG_CAP);
                                    lon_deg_next = tmp[7:0];
                                end else begin
                                    nd_next = 1'b1;
                                end
                            end else begin
                                ndc = (char_reg == 5'd3) ? 1'b0 : nd_reg;
                                nd_next = ndc;
                                if (!ndc) begin
                                    dec = ggap_pkg::take_decimal(c, lon_min_reg, frac_reg,
                                              ap_reg, ggap_pkg::MIN_FRAC_DIGITS,
                                              ggap_pkg::MIN_CAP);
                                    lon_min_next  = dec.acc;
                                    frac_next     = dec.frac;
                                    ap_next       = dec.ap;
                                    nd_next       = dec.nd;
                                    lon_have_next = dec.frac;
                                end
                            end
                        end
                        ggap_pkg::FLD_LON_DIR: begin
                            if (char_reg == 5'd0) begin
                                lon_dir_next = c;
                            end
                        end
                        ggap_pkg::FLD_FIX: begin
                            if (char_reg == 5'd0) begin
                                fix_next = (c == ggap_pkg::CH_ONE);
                            end
                        end
                        ggap_pkg::FLD_SAT: begin
                            if (!nd_reg && ggap_pkg::is_digit(c)) begin
                                tmp = ggap_pkg::sat_push({13'b0, sat_reg}, c[3:0],
                                                         ggap_pkg::SAT_CAP);
                                sat_next = tmp[6:0];
                            end else begin
                                nd_next = 1'b1;
                            end
                        end
                        ggap_pkg::FLD_ALT: begin
                            if (!nd_reg) begin
                                if (char_reg == 5'd0 &&
                                    (c == ggap_pkg::CH_MINUS || c == ggap_pkg::CH_PLUS)) begin
                                    alt_neg_next = (c == ggap_pkg::CH_MINUS);
                                end else begin
                                    dec = ggap_pkg::take_decimal(c, alt_reg, frac_reg, ap_reg,
                                              ggap_pkg::ALT_FRAC_DIGITS,
                                              ggap_pkg::ALT_POS_CAP);
                                    alt_next      = dec.acc;
                                    frac_next     = dec.frac;
                                    ap_next       = dec.ap;
                                    nd_next       = dec.nd;
                                    alt_have_next = dec.frac;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (char_reg != 5'd31) begin
                        char_next = char_reg + 5'd1;
                    end
                end
            end

            // Sentence end: hand over the record, then start clean
            if (newline || cut) begin
                // record taken from the values this byte leaves, before the clear
                q_rec.lat_deg  = lat_deg_next;
                q_rec.lat_min  = lat_min_next;
                q_rec.lat_have = lat_have_next;
                q_rec.lat_long = (lat_len_next >= 5'd6);
                q_rec.lon_deg  = lon_deg_next;
                q_rec.lon_min  = lon_min_next;
                q_rec.lon_have = lon_have_next;
                q_rec.lon_long = (lon_len_next >= 5'd6);
                q_rec.lat_dir  = lat_dir_next;
                q_rec.lon_dir  = lon_dir_next;
                q_rec.alt      = alt_next;
                q_rec.alt_have = alt_have_next;
                q_rec.alt_neg  = alt_neg_next;
                q_rec.sat      = sat_next;
                q_rec.fix      = fix_next;
                q_rec.cut      = cut;
                q_push = header_match_next;
                byte_count_next   = '0;
                header_match_next = 1'b1;
                field_next        = '0;
                char_next         = '0;
                lat_deg_next      = '0;
                lat_min_next      = '0;
                lat_len_next      = '0;
                lat_have_next     = '0;
                lon_deg_next      = '0;
                lon_min_next      = '0;
                lon_len_next      = '0;
                lon_have_next     = '0;
                frac_next         = '0;
                ap_next           = 1'b0;
                nd_next           = 1'b0;
                alt_next          = '0;
                alt_neg_next      = 1'b0;
                alt_have_next     = '0;
                sat_next          = '0;
                lat_dir_next      = '0;
                lon_dir_next      = '0;
                fix_next          = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg   <= '0;
            header_match_reg <= 1'b1;
            field_reg        <= '0;
            char_reg         <= '0;
            lat_deg_reg      <= '0;
            lat_min_reg      <= '0;
            lat_len_reg      <= '0;
            lat_have_reg     <= '0;
            lon_deg_reg      <= '0;
            lon_min_reg      <= '0;
            lon_len_reg      <= '0;
            lon_have_reg     <= '0;
            frac_reg         <= '0;
            ap_reg           <= 1'b0;
            nd_reg           <= 1'b0;
            alt_reg          <= '0;
            alt_neg_reg      <= 1'b0;
            alt_have_reg     <= '0;
            sat_reg          <= '0;
            lat_dir_reg      <= '0;
            lon_dir_reg      <= '0;
            fix_reg          <= 1'b0;
        end else begin
            byte_count_reg   <= byte_count_next;
            header_match_reg <= header_match_next;
            field_reg        <= field_next;
            char_reg         <= char_next;
            lat_deg_reg      <= lat_deg_next;
            lat_min_reg      <= lat_min_next;
            lat_len_reg      <= lat_len_next;
            lat_have_reg     <= lat_have_next;
            lon_deg_reg      <= lon_deg_next;
            lon_min_reg      <= lon_min_next;
            lon_len_reg      <= lon_len_next;
            lon_have_reg     <= lon_have_next;
            frac_reg         <= frac_next;
            ap_reg           <= ap_next;
            nd_reg           <= nd_next;
            alt_reg          <= alt_next;
            alt_neg_reg      <= alt_neg_next;
            alt_have_reg     <= alt_have_next;
            sat_reg          <= sat_next;
            lat_dir_reg      <= lat_dir_next;
            lon_dir_reg      <= lon_dir_next;
            fix_reg          <= fix_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ggap_queue.sv]
// ----------------------------------------------------------------------------
// ggap_queue: short record queue
// Holds finished sentence records between the scanner and the converter.
// ----------------------------------------------------------------------------
`default_nettype none

module ggap_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire ggap_pkg::rec_t push_rec,
    input  wire logic           pop,
    output ggap_pkg::rec_t      head_rec,
    output logic                empty,
    output logic                full
);

    ggap_pkg::rec_t                mem_reg [ggap_pkg::Q_DEPTH];
    logic [ggap_pkg::Q_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ggap_pkg::Q_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ggap_pkg::Q_AW:0]       count_reg, count_next;
    logic                          do_push;
    logic                          do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == (ggap_pkg::Q_AW + 1)'(ggap_pkg::Q_DEPTH));
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = mem_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ggap_back.sv]
// ----------------------------------------------------------------------------
// ggap_back: coordinate and altitude converter
// Four-stage pipeline: fraction scaling, minute scaling, divide by sixty via
// reciprocal multiply, then sum, clamp, sign and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ggap_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire ggap_pkg::rec_t      head_rec,
    input  wire logic                q_empty,
    output logic                     q_pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [27:0]       m_latitude_microdeg,
    output logic signed [28:0]       m_longitude_microdeg,
    output logic [7:0]               m_lat_hemisphere,
    output logic [7:0]               m_lon_hemisphere,
    output logic signed [20:0]       m_altitude_decimetre,
    output logic [6:0]               m_satellites_used,
    output logic                     m_fix_ok,
    output logic                     m_length_cut
);

    // Minutes to microdegrees: floor(min * K / 60) with K = 10^(6 - digits)
    localparam logic [16:0] K       = ggap_pkg::pow10(3'd6 - ggap_pkg::MIN_FRAC_DIGITS);
    localparam int          X_W     = $clog2(((64'd1 << 20) - 64'd1) * 64'(K) / 64'd4 + 64'd1);
    localparam int          SH      = X_W + 4;
    localparam logic [63:0] RECIP64 = ((64'd1 << SH) + 64'd14) / 64'd15;
    localparam int          R_W     = X_W + 1;
    localparam int          Q_W     = X_W - 3;

    // Side fields carried along the pipe
    typedef struct packed {
        logic        lat_long;
        logic        lon_long;
        logic [7:0]  lat_dir;
        logic [7:0]  lon_dir;
        logic [19:0] alt;
        logic        alt_neg;
        logic [6:0]  sat;
        logic        fix;
        logic        cut;
        logic [27:0] lat_e6;
        logic [27:0] lon_e6;
    } side_t;

    logic                 en;
    logic                 v1_reg, v2_reg, v3_reg, out_v_reg;
    side_t                s1_reg, s2_reg, s3_reg, s1_next;
    logic [19:0]          lat_m1_reg, lon_m1_reg;
    logic [X_W-1:0]       lat_x2_reg, lon_x2_reg;
    logic [Q_W-1:0]       lat_q3_reg, lon_q3_reg;
    logic [36:0]          lat_k, lon_k;
    logic [2*X_W:0]       lat_p, lon_p;
    logic [28:0]          lat_mag, lon_mag;
    logic [28:0]          lat_fin, lon_fin;
    logic [19:0]          alt_mag;
    logic [20:0]          alt_fin;

    logic signed [27:0]   lat_out_reg;
    logic signed [28:0]   lon_out_reg;
    logic [7:0]           lat_dir_out_reg, lon_dir_out_reg;
    logic signed [20:0]   alt_out_reg;
    logic [6:0]           sat_out_reg;
    logic                 fix_out_reg, cut_out_reg;

    assign en    = !out_v_reg || m_ready;
    assign q_pop = en && !q_empty;

    // Stage 1 side data: degree scaling and altitude fraction fix-up
    always_comb begin
        s1_next          = '0;
        s1_next.lat_long = head_rec.lat_long;
        s1_next.lon_long = head_rec.lon_long;
        s1_next.lat_dir  = head_rec.lat_dir;
        s1_next.lon_dir  = head_rec.lon_dir;
        s1_next.alt      = ggap_pkg::sat_scale(head_rec.alt, head_rec.alt_have,
                                               ggap_pkg::ALT_FRAC_DIGITS,
                                               ggap_pkg::ALT_POS_CAP);
        s1_next.alt_neg  = head_rec.alt_neg;
        s1_next.sat      = head_rec.sat;
        s1_next.fix      = head_rec.fix;
        s1_next.cut      = head_rec.cut;
        s1_next.lat_e6   = 28'({21'b0, head_rec.lat_deg} * {8'b0, ggap_pkg::MICRO});
        s1_next.lon_e6   = 28'({20'b0, head_rec.lon_deg} * {8'b0, ggap_pkg::MICRO});
    end

    // Stage 2 and 3 arithmetic
    assign lat_k = {17'b0, lat_m1_reg} * {20'b0, K};
    assign lon_k = {17'b0, lon_m1_reg} * {20'b0, K};
    assign lat_p = {{(X_W+1){1'b0}}, lat_x2_reg} * {{X_W{1'b0}}, RECIP64[R_W-1:0]};
    assign lon_p = {{(X_W+1){1'b0}}, lon_x2_reg} * {{X_W{1'b0}}, RECIP64[R_W-1:0]};

    // Output stage: sum, clamp, short-text zero and sign
    always_comb begin
        lat_mag = {1'b0, s3_reg.lat_e6} + 29'(lat_q3_reg);
        lon_mag = {1'b0, s3_reg.lon_e6} + 29'(lon_q3_reg);
        if (lat_mag > ggap_pkg::LAT_CAP) begin
            lat_mag = ggap_pkg::LAT_CAP;
        end
        if (lon_mag > ggap_pkg::LON_CAP) begin
            lon_mag = ggap_pkg::LON_CAP;
        end
        if (!s3_reg.lat_long) begin
            lat_mag = '0;
        end
        if (!s3_reg.lon_long) begin
            lon_mag = '0;
        end
        lat_fin = (s3_reg.lat_dir == ggap_pkg::CH_S || s3_reg.lat_dir == ggap_pkg::CH_W)
                  ? -lat_mag : lat_mag;
        lon_fin = (s3_reg.lon_dir == ggap_pkg::CH_S || s3_reg.lon_dir == ggap_pkg::CH_W)
                  ? -lon_mag : lon_mag;
        alt_mag = s3_reg.alt;
        if (s3_reg.alt_neg && alt_mag > ggap_pkg::ALT_NEG_CAP) begin
            alt_mag = ggap_pkg::ALT_NEG_CAP;
        end
        alt_fin = s3_reg.alt_neg ? -{1'b0, alt_mag} : {1'b0, alt_mag};
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end else if (en) begin
            v1_reg    <= !q_empty;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            out_v_reg <= v3_reg;
        end
    end

    // Data path
    always_ff @(posedge aclk) begin
        if (en) begin
            s1_reg          <= s1_next;
            lat_m1_reg      <= ggap_pkg::sat_scale(head_rec.lat_min, head_rec.lat_have,
                                   ggap_pkg::MIN_FRAC_DIGITS, ggap_pkg::MIN_CAP);
            lon_m1_reg      <= ggap_pkg::sat_scale(head_rec.lon_min, head_rec.lon_have,
                                   ggap_pkg::MIN_FRAC_DIGITS, ggap_pkg::MIN_CAP);
            s2_reg          <= s1_reg;
            lat_x2_reg      <= lat_k[X_W+1:2];
            lon_x2_reg      <= lon_k[X_W+1:2];
            s3_reg          <= s2_reg;
            lat_q3_reg      <= lat_p[SH +: Q_W];
            lon_q3_reg      <= lon_p[SH +: Q_W];
            lat_out_reg     <= lat_fin[27:0];
            lon_out_reg     <= lon_fin;
            lat_dir_out_reg <= s3_reg.lat_dir;
            lon_dir_out_reg <= s3_reg.lon_dir;
            alt_out_reg     <= alt_fin;
            sat_out_reg     <= s3_reg.sat;
            fix_out_reg     <= s3_reg.fix;
            cut_out_reg     <= s3_reg.cut;
        end
    end

    assign m_valid              = out_v_reg;
    assign m_latitude_microdeg  = lat_out_reg;
    assign m_longitude_microdeg = lon_out_reg;
    assign m_lat_hemisphere     = lat_dir_out_reg;
    assign m_lon_hemisphere     = lon_dir_out_reg;
    assign m_altitude_decimetre = alt_out_reg;
    assign m_satellites_used    = sat_out_reg;
    assign m_fix_ok             = fix_out_reg;
    assign m_length_cut         = cut_out_reg;

endmodule

`default_nettype wire

[hw/rtl/gga_sentence_parser.sv]
// ----------------------------------------------------------------------------
// gga_sentence_parser: GGA position sentence parser
// Takes one byte per cycle while the record queue has room; every byte,
// including the one that ends a sentence, is accepted in any scanner state.
// The edge that takes the byte ending a matched sentence writes its record
// to the queue; the result is valid once the record has passed the four
// converter stages, and at most one result leaves per cycle.
// Input stalls only while the four-entry record queue is full.
// Synchronous active-low reset clears scanner, queue and pipeline valids.
// ----------------------------------------------------------------------------
`default_nettype none

module gga_sentence_parser #(
    parameter int MAX_SENTENCE = 128
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [7:0]          s_rx_byte,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [27:0]       m_latitude_microdeg,
    output logic signed [28:0]       m_longitude_microdeg,
    output logic [7:0]               m_lat_hemisphere,
    output logic [7:0]               m_lon_hemisphere,
    output logic signed [20:0]       m_altitude_decimetre,
    output logic [6:0]               m_satellites_used,
    output logic                     m_fix_ok,
    output logic                     m_length_cut
);

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    logic            q_full;
    ggap_pkg::rec_t  push_rec;
    ggap_pkg::rec_t  head_rec;

    // Byte scanner
    ggap_front #(
        .MAX_SENTENCE(MAX_SENTENCE)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_rx_byte(s_rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    // Record queue
    ggap_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .push_rec(push_rec),
        .pop     (q_pop),
        .head_rec(head_rec),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Converter
    ggap_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .head_rec             (head_rec),
        .q_empty              (q_empty),
        .q_pop                (q_pop),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_latitude_microdeg  (m_latitude_microdeg),
        .m_longitude_microdeg (m_longitude_microdeg),
        .m_lat_hemisphere     (m_lat_hemisphere),
        .m_lon_hemisphere     (m_lon_hemisphere),
        .m_altitude_decimetre (m_altitude_decimetre),
        .m_satellites_used    (m_satellites_used),
        .m_fix_ok             (m_fix_ok),
        .m_length_cut         (m_length_cut)
    );

endmodule

`default_nettype wire
